// ----- rtl/crcrg_pkg.sv -----
// ----------------------------------------------------------------------------
// crcrg_pkg
// widths, reset values and register indexes for the crc generate/check core
// ----------------------------------------------------------------------------
package crcrg_pkg;

    // fixed field widths
    localparam int CHUNK_W    = 8;
    localparam int COUNT_W    = 4;
    localparam int REM_W      = 32;
    localparam int POLY_W     = 32;
    localparam int DEG_W      = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // defaults for the top level parameters
    localparam int MAX_DEGREE_DEF = 32;
    localparam int LANE_BITS_DEF  = 8;

    // register reset values
    localparam logic [POLY_W-1:0] POLY_LOW_RST   = 32'h04C1_1DB7;
    localparam logic [DEG_W-1:0]  POLY_DEGREE_RST = 6'd32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLY_LOW_TERMS = 4'd0,
        REG_POLY_DEGREE    = 4'd1
    } cfg_reg_t;

endpackage

// ----- rtl/crcrg_if.sv -----
// ----------------------------------------------------------------------------
// crcrg_if
// valid/ready channels of the crc generate/check core
// ----------------------------------------------------------------------------
interface crcrg_chunk_if;
    logic                         valid;
    logic                         ready;
    logic [crcrg_pkg::CHUNK_W-1:0] chunk_bits;
    logic [crcrg_pkg::COUNT_W-1:0] bit_count;
    logic                         last_chunk;

    modport source (output valid, output chunk_bits, output bit_count,
                    output last_chunk, input ready);
    modport sink   (input valid, input chunk_bits, input bit_count,
                    input last_chunk, output ready);
endinterface

interface crcrg_result_if;
    logic                        valid;
    logic                        ready;
    logic [crcrg_pkg::REM_W-1:0] remainder;
    logic                        accepted;

    modport source (output valid, output remainder, output accepted, input ready);
    modport sink   (input valid, input remainder, input accepted, output ready);
endinterface

interface crcrg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [crcrg_pkg::CFG_IDX_W-1:0]  index;
    logic [crcrg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/crcrg_lane.sv -----
// ----------------------------------------------------------------------------
// crcrg_lane
// one serial division step: shift the remainder by one message bit
// ----------------------------------------------------------------------------
module crcrg_lane #(
    parameter int MAX_DEGREE = crcrg_pkg::MAX_DEGREE_DEF
) (
    input  logic                                   en,
    input  logic                                   msg_bit,
    input  logic [(MAX_DEGREE > 1 ? $clog2(MAX_DEGREE) : 1)-1:0] top_idx,
    input  logic [MAX_DEGREE-1:0]                  mask,
    input  logic [MAX_DEGREE-1:0]                  poly,
    input  logic [MAX_DEGREE-1:0]                  rem_in,
    output logic [MAX_DEGREE-1:0]                  rem_out
);

    logic                  fb;
    logic [MAX_DEGREE-1:0] shifted;

    always_comb
    begin
        fb      = rem_in[top_idx] ^ msg_bit;
        shifted = (rem_in << 1) & mask;
        if (!en)
            rem_out = rem_in;
        else if (fb)
            rem_out = shifted ^ poly;
        else
            rem_out = shifted;
    end

endmodule

// ----- rtl/crcrg_merge.sv -----
// ----------------------------------------------------------------------------
// crcrg_merge
// takes the remainder after the last lane, forms the result and holds it
// ----------------------------------------------------------------------------
module crcrg_merge #(
    parameter int MAX_DEGREE = crcrg_pkg::MAX_DEGREE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [MAX_DEGREE-1:0] rem_final,
    output logic                  space,
    crcrg_result_if.source        result
);

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [crcrg_pkg::REM_W-1:0]     remainder_reg;
    logic                            accepted_reg;
    logic [MAX_DEGREE+crcrg_pkg::REM_W-1:0] rem_wide;

    assign space    = !out_valid_reg || result.ready;
    assign rem_wide = {{crcrg_pkg::REM_W{1'b0}}, rem_final};

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            remainder_reg <= rem_wide[crcrg_pkg::REM_W-1:0];
            accepted_reg  <= (rem_final == '0);
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.remainder = remainder_reg;
    assign result.accepted  = accepted_reg;

endmodule

// ----- rtl/crc_remainder_generate_check_core.sv -----
// ----------------------------------------------------------------------------
// crc_remainder_generate_check_core
// crc remainder over a chunked message with a configurable generator
//
// channel  role    payload
// chunk    sink    chunk_bits[7:0], bit_count[3:0], last_chunk
// result   source  remainder[31:0], accepted
// cfg      sink    index[3:0], data[31:0]
//
// one chunk per cycle unless the output register stalls it: LANE_BITS bit-step
// lanes are chained combinationally and the running remainder register closes
// the loop between chunks. a result shows up in the cycle after its last chunk
// transfer, from the output register; a chunk is taken while that register is
// empty or being drained. reset puts the crc-32 generator in place and clears
// the running remainder. cfg writes are taken every cycle.
// ----------------------------------------------------------------------------
module crc_remainder_generate_check_core #(
    parameter int MAX_DEGREE = crcrg_pkg::MAX_DEGREE_DEF,
    parameter int LANE_BITS  = crcrg_pkg::LANE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    crcrg_chunk_if.sink    chunk,
    crcrg_result_if.source result,
    crcrg_cfg_if.sink      cfg
);

    localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    logic [crcrg_pkg::POLY_W-1:0] poly_low_reg;
    logic [crcrg_pkg::DEG_W-1:0]  poly_degree_reg;
    logic [MAX_DEGREE-1:0]        running_reg;
    logic [MAX_DEGREE-1:0]        running_next;

    logic [IW-1:0]                top_idx;
    logic [MAX_DEGREE-1:0]        mask;
    logic [MAX_DEGREE-1:0]        poly;
    logic [MAX_DEGREE+crcrg_pkg::POLY_W-1:0] poly_wide;
    logic [MAX_DEGREE-1:0]        lane_rem [LANE_BITS+1];
    logic                         space;
    logic                         in_xfer;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_low_reg    <= crcrg_pkg::POLY_LOW_RST;
            poly_degree_reg <= crcrg_pkg::POLY_DEGREE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                crcrg_pkg::REG_POLY_LOW_TERMS:
                    poly_low_reg <= cfg.data;
                crcrg_pkg::REG_POLY_DEGREE:
                    poly_degree_reg <= cfg.data[crcrg_pkg::DEG_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // effective degree clamped to 1..MAX_DEGREE, kept as the index of its top bit
    always_comb
    begin
        if (poly_degree_reg == '0)
            top_idx = '0;
        else if (int'(poly_degree_reg) > MAX_DEGREE)
            top_idx = IW'(MAX_DEGREE - 1);
        else
            top_idx = IW'(poly_degree_reg - 6'd1);
    end

    always_comb
    begin
        for (int k = 0; k < MAX_DEGREE; k++)
            mask[k] = (int'(top_idx) >= k);
    end

    assign poly_wide = {{MAX_DEGREE{1'b0}}, poly_low_reg};
    assign poly      = poly_wide[MAX_DEGREE-1:0] & mask;

    // lane chain, first message bit in lane 0
    assign lane_rem[0] = running_reg & mask;

    for (genvar i = 0; i < LANE_BITS; i++)
    begin : g_lane
        localparam int POS = LANE_BITS - 1 - i;
        logic msg_bit;
        logic en;

        if (POS < crcrg_pkg::CHUNK_W)
        begin : g_bit
            assign msg_bit = chunk.chunk_bits[POS];
        end
        else
        begin : g_zero
            assign msg_bit = 1'b0;
        end

        assign en = (32'(chunk.bit_count) > 32'(i));

        crcrg_lane #(
            .MAX_DEGREE (MAX_DEGREE)
        ) u_lane (
            .en      (en),
            .msg_bit (msg_bit),
            .top_idx (top_idx),
            .mask    (mask),
            .poly    (poly),
            .rem_in  (lane_rem[i]),
            .rem_out (lane_rem[i+1])
        );
    end

    assign chunk.ready = space;
    assign in_xfer     = chunk.valid && space;

    always_comb
    begin
        running_next = running_reg;
        if (in_xfer)
            running_next = chunk.last_chunk ? '0 : lane_rem[LANE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            running_reg <= '0;
        else
            running_reg <= running_next;
    end

    crcrg_merge #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_xfer && chunk.last_chunk),
        .rem_final (lane_rem[LANE_BITS]),
        .space     (space),
        .result    (result)
    );

endmodule
